>>> rtl/mbao_pkg.sv
// package for the masked box alpha overlay
// item and config types shared by all rtl files, register index type, clamp and blend helpers
`default_nettype none
package mbao_pkg;

  localparam int unsigned CoordW = 16;

  typedef enum logic [1:0] {
    CMD_WR_PAL = 2'd0,
    CMD_WR_DET = 2'd1,
    CMD_BLEND  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ALPHA  = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_DETCNT = 3'd3,
    REG_CLSCNT = 3'd4
  } reg_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        slot;
    logic [7:0]        b;
    logic [7:0]        g;
    logic [7:0]        r;
    logic [15:0]       left;
    logic [15:0]       top;
    logic [15:0]       right;
    logic [15:0]       bottom;
    logic              act;
    logic [15:0]       cls;
    logic [15:0]       mask;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              fend;
  } item_t;

  typedef struct packed {
    logic [8:0]  alpha;
    logic [15:0] wm1;
    logic [15:0] hm1;
    logic [6:0]  n;
    logic [15:0] ccm1;
  } cfg_t;

  function automatic logic [15:0] clamp_s16(logic [15:0] v, logic [15:0] hi);
    logic [15:0] res;
    if ($signed(v) < 0) begin
      res = 16'd0;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [7:0] blend8(logic [7:0] d, logic [7:0] s, logic [8:0] a);
    logic [17:0] acc;
    acc = 18'(9'd256 - a) * 18'(d) + 18'(a) * 18'(s) + 18'd128;
    return acc[15:8];
  endfunction

endpackage
`default_nettype wire

>>> rtl/mbao_front.sv
// input register with raster column and row counters
// depends on mbao_pkg
`default_nettype none
module mbao_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           vld_i,
  input  mbao_pkg::item_t     item_i,
  input  mbao_pkg::cfg_t      cfg_i,
  output logic                vld_o,
  output mbao_pkg::item_t     item_o
);

  logic [mbao_pkg::CoordW-1:0] x_q, x_d, y_q, y_d;
  logic                        vld_q;
  mbao_pkg::item_t             item_q, item_d;
  logic                        wrap_col, wrap_row, is_pix;

  always_comb begin
    is_pix   = vld_i && (item_i.cmd == mbao_pkg::CMD_BLEND);
    wrap_col = x_q >= cfg_i.wm1;
    wrap_row = wrap_col && (y_q >= cfg_i.hm1);
    x_d = x_q;
    y_d = y_q;
    if (is_pix) begin
      if (wrap_col) begin
        x_d = '0;
        y_d = wrap_row ? '0 : y_q + 1'b1;
      end else begin
        x_d = x_q + 1'b1;
      end
    end
    item_d      = item_i;
    item_d.x    = x_q;
    item_d.y    = y_q;
    item_d.fend = wrap_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      vld_q <= 1'b0;
    end else if (adv_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

>>> rtl/mbao_stage.sv
// one detection stage: detection entry, palette copy, box test and blend
// depends on mbao_pkg
`default_nettype none
module mbao_stage #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           vld_i,
  input  mbao_pkg::item_t     item_i,
  input  mbao_pkg::cfg_t      cfg_i,
  output logic                vld_o,
  output mbao_pkg::item_t     item_o
);

  localparam int unsigned PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] rdata_q;
  logic [15:0] dl_q, dt_q, dr_q, db_q, dc_q;
  logic        da_q;

  logic            a_vld_q, b_vld_q, b_hit_q;
  mbao_pkg::item_t a_item_q, b_item_q, out_item;
  logic [23:0]     b_col_q;

  logic [15:0] x1, x2, y1, y2, cls;
  logic [PW-1:0] raddr;
  logic        hit;

  // detection entry and palette copy follow writes as they enter the stage
  always_ff @(posedge clk_i) begin
    if (adv_i && vld_i && item_i.cmd == mbao_pkg::CMD_WR_DET && 32'(item_i.slot) == IDX) begin
      dl_q <= item_i.left;
      dt_q <= item_i.top;
      dr_q <= item_i.right;
      db_q <= item_i.bottom;
      da_q <= item_i.act;
      dc_q <= item_i.cls;
    end
    if (adv_i && vld_i && item_i.cmd == mbao_pkg::CMD_WR_PAL &&
        32'(item_i.slot) < PALETTE_DEPTH) begin
      pal_mem[PW'(item_i.slot)] <= {item_i.r, item_i.g, item_i.b};
    end
    rdata_q <= pal_mem[raddr];
  end

  always_comb begin
    x1    = mbao_pkg::clamp_s16(dl_q, cfg_i.wm1);
    x2    = mbao_pkg::clamp_s16(dr_q, cfg_i.wm1);
    y1    = mbao_pkg::clamp_s16(dt_q, cfg_i.hm1);
    y2    = mbao_pkg::clamp_s16(db_q, cfg_i.hm1);
    cls   = mbao_pkg::clamp_s16(dc_q, cfg_i.ccm1);
    raddr = cls[PW-1:0];
    hit   = (a_item_q.cmd == mbao_pkg::CMD_BLEND) && da_q && (IDX < 32'(cfg_i.n)) &&
            (x2 > x1) && (y2 > y1) &&
            (a_item_q.x >= x1) && (a_item_q.x < x2) &&
            (a_item_q.y >= y1) && (a_item_q.y < y2);
    if (IDX >= 16) begin
      hit = 1'b0;
    end else begin
      hit = hit && a_item_q.mask[IDX[3:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_item_q <= item_i;
      b_item_q <= a_item_q;
      b_hit_q  <= hit;
      b_col_q  <= rdata_q;
    end
  end

  always_comb begin
    out_item = b_item_q;
    if (b_hit_q) begin
      out_item.b = mbao_pkg::blend8(b_item_q.b, b_col_q[7:0], cfg_i.alpha);
      out_item.g = mbao_pkg::blend8(b_item_q.g, b_col_q[15:8], cfg_i.alpha);
      out_item.r = mbao_pkg::blend8(b_item_q.r, b_col_q[23:16], cfg_i.alpha);
    end
  end

  assign vld_o  = b_vld_q;
  assign item_o = out_item;

endmodule
`default_nettype wire

>>> rtl/masked_box_alpha_overlay.sv
// masked box alpha overlay top level: config registers, stage chain, output register
// depends on mbao_pkg, mbao_front and mbao_stage
//
// One item is taken per clock while the output side takes results. Every item walks
// through an input register, two registers per detection stage and an output register
// before its pixel is offered on the output; the whole chain moves on one enable, and
// palette and detection writes take effect in stream order because each stage updates
// its own palette copy and entry as the write passes it.
`default_nettype none
module masked_box_alpha_overlay #(
  parameter int unsigned MAX_DETECTIONS = 16,
  parameter int unsigned PALETTE_DEPTH  = 256,
  parameter int unsigned MAX_DIMENSION  = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [12:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot, color_b, color_g, color_r, box_left, box_top, box_right, box_bottom,
  // detection_active, detection_class, mask_bits
  input  wire logic [135:0] s_axis_tdata,
  // command
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_b, out_g, out_r
  output logic [23:0]       m_axis_tdata,
  // frame_end
  output logic              m_axis_tlast
);

  logic [8:0]  alpha_q;
  logic [12:0] width_q, height_q;
  logic [4:0]  detcnt_q;
  logic [8:0]  clscnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 9'd128;
      width_q  <= 13'd640;
      height_q <= 13'd640;
      detcnt_q <= 5'd0;
      clscnt_q <= 9'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mbao_pkg::REG_ALPHA:  alpha_q  <= cfg_wdata_i[8:0];
        mbao_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        mbao_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        mbao_pkg::REG_DETCNT: detcnt_q <= cfg_wdata_i[4:0];
        mbao_pkg::REG_CLSCNT: clscnt_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  mbao_pkg::cfg_t cfg;
  logic [15:0]    w_lim, h_lim, cc_lim;

  always_comb begin
    w_lim = (width_q == '0) ? 16'd1 :
            (32'(width_q) > MAX_DIMENSION) ? 16'(MAX_DIMENSION) : 16'(width_q);
    h_lim = (height_q == '0) ? 16'd1 :
            (32'(height_q) > MAX_DIMENSION) ? 16'(MAX_DIMENSION) : 16'(height_q);
    cc_lim = (clscnt_q == '0) ? 16'd1 :
             (32'(clscnt_q) > PALETTE_DEPTH) ? 16'(PALETTE_DEPTH) : 16'(clscnt_q);
    cfg.alpha = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
    cfg.wm1   = w_lim - 16'd1;
    cfg.hm1   = h_lim - 16'd1;
    cfg.n     = (32'(detcnt_q) > MAX_DETECTIONS) ? 7'(MAX_DETECTIONS) : 7'(detcnt_q);
    cfg.ccm1  = cc_lim - 16'd1;
  end

  logic            adv;
  logic            out_vld_q;
  logic [23:0]     out_data_q;
  logic            out_last_q;
  mbao_pkg::item_t in_item;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    in_item        = '0;
    in_item.cmd    = mbao_pkg::cmd_e'(s_axis_tuser);
    in_item.slot   = s_axis_tdata[7:0];
    in_item.b      = s_axis_tdata[15:8];
    in_item.g      = s_axis_tdata[23:16];
    in_item.r      = s_axis_tdata[31:24];
    in_item.left   = s_axis_tdata[47:32];
    in_item.top    = s_axis_tdata[63:48];
    in_item.right  = s_axis_tdata[79:64];
    in_item.bottom = s_axis_tdata[95:80];
    in_item.act    = s_axis_tdata[96];
    in_item.cls    = s_axis_tdata[112:97];
    in_item.mask   = s_axis_tdata[128:113];
  end

  logic            vld_c  [MAX_DETECTIONS+1];
  mbao_pkg::item_t item_c [MAX_DETECTIONS+1];

  mbao_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_axis_tvalid),
    .item_i (in_item),
    .cfg_i  (cfg),
    .vld_o  (vld_c[0]),
    .item_o (item_c[0])
  );

  for (genvar i = 0; i < MAX_DETECTIONS; i++) begin : g_stage
    mbao_stage #(
      .IDX           (i),
      .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (vld_c[i]),
      .item_i (item_c[i]),
      .cfg_i  (cfg),
      .vld_o  (vld_c[i+1]),
      .item_o (item_c[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_c[MAX_DETECTIONS] &&
                   (item_c[MAX_DETECTIONS].cmd == mbao_pkg::CMD_BLEND);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {item_c[MAX_DETECTIONS].r, item_c[MAX_DETECTIONS].g,
                     item_c[MAX_DETECTIONS].b};
      out_last_q <= item_c[MAX_DETECTIONS].fend;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
